>>> design/triangle_screen_map_and_cull_unit_defines.svh
// Assertion macros shared by the triangle screen map and cull unit.
`ifndef TRIANGLE_SCREEN_MAP_AND_CULL_UNIT_DEFINES_SVH
`define TRIANGLE_SCREEN_MAP_AND_CULL_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TSCM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define TSCM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TSCM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define TSCM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

>>> design/tscm_pkg.sv
// Shared types and constants of the triangle screen map and cull unit.
`default_nettype none
package tscm_pkg;
    localparam int SCREEN_WIDTH_DEF  = 1024;
    localparam int SCREEN_HEIGHT_DEF = 768;

    localparam int IN_W       = 32;
    localparam int INT_W      = 16;
    localparam int FRAC_W     = 30;
    localparam int Q_W        = 30;
    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = Q_W / DIV_STEP;
    // Sum, scale, magnitude, overflow check, divider stages, saturation.
    localparam int MAP_LAT    = 4 + DIV_STAGES + 1;

    localparam logic [1:0] VERD_DRAWN  = 2'd0;
    localparam logic [1:0] VERD_BEHIND = 2'd1;
    localparam logic [1:0] VERD_BACK   = 2'd2;

    typedef struct packed {
        logic signed [INT_W-1:0]  ix;
        logic signed [INT_W-1:0]  iy;
        logic signed [FRAC_W-1:0] fx;
        logic signed [FRAC_W-1:0] fy;
    } t_vtx;

    typedef struct packed {
        logic vld;
        logic behind;
    } t_ctl;
endpackage
`default_nettype wire

>>> design/tscm_coord_map.sv
// One screen coordinate: scale, pipelined restoring divide by w, saturation.
`default_nettype none
module tscm_coord_map #(
    parameter int HALF = tscm_pkg::SCREEN_WIDTH_DEF / 2,
    parameter bit SUB  = 1'b0
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic signed [tscm_pkg::IN_W-1:0]  i_coord,
    input  wire logic signed [tscm_pkg::IN_W-1:0]  i_w,
    output logic signed [tscm_pkg::INT_W-1:0]      o_int,
    output logic signed [tscm_pkg::FRAC_W-1:0]     o_frac
);
    localparam int NS = tscm_pkg::DIV_STAGES;
    localparam int QW = tscm_pkg::Q_W;
    localparam logic signed [14:0] HALF_C = 15'(HALF);

    logic signed [33:0] r_num;
    logic [30:0]        r_wa, r_wb, r_wc;
    logic signed [47:0] r_prod;
    logic               r_negc;
    logic [45:0]        r_mag;
    logic signed [47:0] n_prod;
    logic [45:0]        n_mag;

    logic [30:0]   r_rem [NS+1];
    logic [QW-1:0] r_d   [NS+1];
    logic [QW-1:0] r_q   [NS+1];
    logic [30:0]   r_w   [NS+1];
    logic          r_ng  [NS+1];
    logic          r_ov  [NS+1];

    // Numerator w plus or minus the coordinate, then scaled by half the screen.
    assign n_prod = 48'(r_num) * 48'(HALF_C);
    assign n_mag  = r_prod[47] ? 46'(-r_prod) : r_prod[45:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (SUB) begin
                r_num <= {{2{i_w[31]}}, i_w} - {{2{i_coord[31]}}, i_coord};
            end else begin
                r_num <= {{2{i_w[31]}}, i_w} + {{2{i_coord[31]}}, i_coord};
            end
            r_wa   <= i_w[30:0];
            r_prod <= n_prod;
            r_wb   <= r_wa;
            r_negc <= r_prod[47];
            r_mag  <= n_mag;
            r_wc   <= r_wb;
            // The quotient overflows the needed range when mag >= w * 2^16.
            r_ov[0]  <= {1'b0, r_mag} >= {r_wc, 16'b0};
            r_rem[0] <= {1'b0, r_mag[45:16]};
            r_d[0]   <= {r_mag[15:0], 14'b0};
            r_q[0]   <= '0;
            r_w[0]   <= r_wc;
            r_ng[0]  <= r_negc;
        end
    end

    // Divider stages, a few quotient bits each.
    for (genvar s = 0; s < NS; s++) begin : g_div
        logic [30:0]   n_rem;
        logic [QW-1:0] n_d, n_q;

        always_comb begin : p_step
            logic [31:0] r2;
            n_rem = r_rem[s];
            n_d   = r_d[s];
            n_q   = r_q[s];
            for (int j = 0; j < tscm_pkg::DIV_STEP; j++) begin
                r2  = {n_rem, n_d[QW-1]};
                n_d = {n_d[QW-2:0], 1'b0};
                if (r2 >= {1'b0, r_w[s]}) begin
                    n_rem = 31'(r2 - {1'b0, r_w[s]});
                    n_q   = {n_q[QW-2:0], 1'b1};
                end else begin
                    n_rem = r2[30:0];
                    n_q   = {n_q[QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_rem;
                r_d[s+1]   <= n_d;
                r_q[s+1]   <= n_q;
                r_w[s+1]   <= r_w[s];
                r_ng[s+1]  <= r_ng[s];
                r_ov[s+1]  <= r_ov[s];
            end
        end
    end

    // Saturate the integer and fraction results and restore the sign.
    logic [QW-1:0]                 q_fin;
    logic [15:0]                   m_int;
    logic signed [tscm_pkg::INT_W-1:0]  n_int;
    logic signed [tscm_pkg::FRAC_W-1:0] n_frac;

    assign q_fin = r_q[NS];
    assign m_int = q_fin[29:14];

    always_comb begin
        if (r_ng[NS]) begin
            n_int  = (r_ov[NS] || m_int[15]) ? 16'sh8000 : 16'(16'd0 - m_int);
            n_frac = (r_ov[NS] || q_fin[29]) ? 30'sh2000_0000 : 30'(30'd0 - q_fin);
        end else begin
            n_int  = (r_ov[NS] || m_int[15]) ? 16'sh7fff : m_int;
            n_frac = (r_ov[NS] || q_fin[29]) ? 30'sh1fff_ffff : q_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_int  <= n_int;
            o_frac <= n_frac;
        end
    end
endmodule
`default_nettype wire

>>> design/tscm_cull.sv
// Cross product winding test, verdict and the output register.
`default_nettype none
module tscm_cull (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_cull_en,
    input  wire logic                            i_snap,
    input  wire tscm_pkg::t_ctl                  i_ctl,
    input  wire tscm_pkg::t_vtx                  i_vtx [3],
    output logic                                 o_vld,
    output logic                                 o_drawn,
    output logic [1:0]                           o_verdict,
    output logic signed [tscm_pkg::INT_W-1:0]    o_sx [3],
    output logic signed [tscm_pkg::INT_W-1:0]    o_sy [3]
);
    logic signed [tscm_pkg::FRAC_W-1:0] cx [3];
    logic signed [tscm_pkg::FRAC_W-1:0] cy [3];
    tscm_pkg::t_ctl r_ctl_d1, r_ctl_d2;
    tscm_pkg::t_vtx r_vtx_d1 [3];
    tscm_pkg::t_vtx r_vtx_d2 [3];
    logic signed [30:0] r_e1x, r_e1y, r_e2x, r_e2y;
    logic signed [61:0] r_p1, r_p2;
    logic signed [62:0] cross_prod;
    logic               front;

    // Cull coordinates are the integer results or the Q16.14 fractions.
    for (genvar k = 0; k < 3; k++) begin : g_sel
        assign cx[k] = i_snap ? {{14{i_vtx[k].ix[15]}}, i_vtx[k].ix} : i_vtx[k].fx;
        assign cy[k] = i_snap ? {{14{i_vtx[k].iy[15]}}, i_vtx[k].iy} : i_vtx[k].fy;
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_d1 <= '0;
            r_ctl_d2 <= '0;
            o_vld    <= 1'b0;
        end else if (i_en) begin
            r_ctl_d1 <= i_ctl;
            r_ctl_d2 <= r_ctl_d1;
            o_vld    <= r_ctl_d2.vld;
        end
    end

    // Edge vectors, then the two products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e1x    <= 31'(cx[1]) - 31'(cx[0]);
            r_e1y    <= 31'(cy[1]) - 31'(cy[0]);
            r_e2x    <= 31'(cx[2]) - 31'(cx[0]);
            r_e2y    <= 31'(cy[2]) - 31'(cy[0]);
            r_vtx_d1 <= i_vtx;
            r_p1     <= 62'(r_e1x) * 62'(r_e2y);
            r_p2     <= 62'(r_e1y) * 62'(r_e2x);
            r_vtx_d2 <= r_vtx_d1;
        end
    end

    assign cross_prod = 63'(r_p1) - 63'(r_p2);
    assign front = !cross_prod[62] && (cross_prod != '0);

    // Verdict and screen coordinates into the output register.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ctl_d2.behind) begin
                o_verdict <= tscm_pkg::VERD_BEHIND;
                o_drawn   <= 1'b0;
            end else if (i_cull_en && !front) begin
                o_verdict <= tscm_pkg::VERD_BACK;
                o_drawn   <= 1'b0;
            end else begin
                o_verdict <= tscm_pkg::VERD_DRAWN;
                o_drawn   <= 1'b1;
            end
            for (int k = 0; k < 3; k++) begin
                o_sx[k] <= r_ctl_d2.behind ? '0 : r_vtx_d2[k].ix;
                o_sy[k] <= r_ctl_d2.behind ? '0 : r_vtx_d2[k].iy;
            end
        end
    end
endmodule
`default_nettype wire

>>> design/triangle_screen_map_and_cull_unit.sv
// Top level of the triangle screen map and cull unit.
//
// Channel   Direction  Beat contents
// s_axis    in         three vertices (x, y, w), signed Q16.16
// m_axis    out        drawn, verdict, six saturated screen coordinates
// cfg       in         write of cull_enable (0) or snap_before_cull (1)
//
// One triangle is accepted per cycle while m_axis is not stalled; its result beat
// passes through four setup stages, the
// ten-stage restoring divider, saturation and three cull stages.
// Reset clears the valid bits and sets cull_enable to 1, snap_before_cull to 0.
// A stall on m_axis freezes the whole pipeline and drops s_axis tready.
`default_nettype none
`include "triangle_screen_map_and_cull_unit_defines.svh"
module triangle_screen_map_and_cull_unit #(
    parameter int SCREEN_WIDTH  = tscm_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tscm_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // v0_x, v0_y, v0_w, v1_x, v1_y, v1_w, v2_x, v2_y, v2_w
    input  wire logic [287:0]  i_s_axis_tdata,
    output logic               o_m_axis_tvalid,
    input  wire logic          i_m_axis_tready,
    // drawn, verdict, s0_x, s0_y, s1_x, s1_y, s2_x, s2_y, zero fill
    output logic [103:0]       o_m_axis_tdata,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_idx,
    input  wire logic [0:0]    i_cfg_data
);
    localparam int LAT = tscm_pkg::MAP_LAT;
    localparam logic CFG_CULL = 1'b0;
    localparam logic CFG_SNAP = 1'b1;

    logic r_cull_en, r_snap;
    logic en, behind;
    logic r_vld [LAT];
    logic r_bhd [LAT];
    tscm_pkg::t_vtx map_vtx [3];
    tscm_pkg::t_ctl map_ctl;
    logic              out_drawn;
    logic [1:0]        out_verdict;
    logic signed [15:0] out_sx [3];
    logic signed [15:0] out_sy [3];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cull_en <= 1'b1;
            r_snap    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CULL: r_cull_en <= i_cfg_data[0];
                CFG_SNAP: r_snap    <= i_cfg_data[0];
                default:  r_snap    <= r_snap;
            endcase
        end
    end

    // The pipeline moves whenever the output register is free.
    assign en = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    assign behind = i_s_axis_tdata[95] || (i_s_axis_tdata[95:64] == '0) ||
                    i_s_axis_tdata[191] || (i_s_axis_tdata[191:160] == '0) ||
                    i_s_axis_tdata[287] || (i_s_axis_tdata[287:256] == '0);

    // Valid and behind-camera flags alongside the coordinate pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LAT; s++) begin
                r_vld[s] <= 1'b0;
                r_bhd[s] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_s_axis_tvalid;
            r_bhd[0] <= behind;
            for (int s = 1; s < LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
                r_bhd[s] <= r_bhd[s-1];
            end
        end
    end

    assign map_ctl = '{vld: r_vld[LAT-1], behind: r_bhd[LAT-1]};

    // Six coordinate mappers, x and y for each vertex.
    for (genvar k = 0; k < 3; k++) begin : g_vtx
        tscm_coord_map #(.HALF(SCREEN_WIDTH / 2), .SUB(1'b0)) u_map_x (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_coord(i_s_axis_tdata[96*k +: 32]),
            .i_w    (i_s_axis_tdata[96*k + 64 +: 32]),
            .o_int  (map_vtx[k].ix),
            .o_frac (map_vtx[k].fx)
        );
        tscm_coord_map #(.HALF(SCREEN_HEIGHT / 2), .SUB(1'b1)) u_map_y (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_coord(i_s_axis_tdata[96*k + 32 +: 32]),
            .i_w    (i_s_axis_tdata[96*k + 64 +: 32]),
            .o_int  (map_vtx[k].iy),
            .o_frac (map_vtx[k].fy)
        );
    end

    tscm_cull u_cull (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_cull_en(r_cull_en),
        .i_snap   (r_snap),
        .i_ctl    (map_ctl),
        .i_vtx    (map_vtx),
        .o_vld    (o_m_axis_tvalid),
        .o_drawn  (out_drawn),
        .o_verdict(out_verdict),
        .o_sx     (out_sx),
        .o_sy     (out_sy)
    );

    assign o_m_axis_tdata = {5'b0, out_sy[2], out_sx[2], out_sy[1], out_sx[1],
                             out_sy[0], out_sx[0], out_verdict, out_drawn};

    `TSCM_ASSERT_IMP(a_behind_zero, i_clk, i_rst_n,
        o_m_axis_tvalid && (out_verdict == tscm_pkg::VERD_BEHIND),
        (o_m_axis_tdata[98:3] == '0), "behind-camera result carries coordinates")
    `TSCM_ASSERT_IMP(a_drawn_match, i_clk, i_rst_n, o_m_axis_tvalid,
        out_drawn == (out_verdict == tscm_pkg::VERD_DRAWN), "drawn disagrees with verdict")
    `TSCM_ASSERT_IMP(a_no_cull, i_clk, i_rst_n, o_m_axis_tvalid && !r_cull_en,
        out_verdict != tscm_pkg::VERD_BACK, "back facing verdict with culling off")
    `TSCM_ASSERT_NXT(a_enter, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready,
        r_vld[0], "accepted beat did not enter the pipeline")
endmodule
`default_nettype wire
